FILE: hdl/trm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_pkg
// Types, codes and sizes shared by the per-type traffic rate meter.
// ----------------------------------------------------------------------------
package trm_pkg;

   localparam int NUM_TYPES  = 16;
   localparam int TYPE_IDX_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_RATE_WINDOW = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SIZE    = 1'd1;

   localparam logic [15:0] RATE_WINDOW_RESET = 16'd1000;
   localparam logic [15:0] MIN_SIZE_RESET    = 16'd4;

   localparam logic [1:0] FUNC_SENT   = 2'd0;
   localparam logic [1:0] FUNC_RECV   = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE = 2'd2;
   localparam logic [1:0] FUNC_ABSENT = 2'd3;

   // index order: sent bytes, received bytes, sent packets, received packets
   typedef logic [3:0][63:0] quad64_type;
   typedef logic [3:0][31:0] quad32_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  packet_type;
      logic [15:0] packet_size;
      logic [31:0] current_time_ms;
      logic [31:0] host_sent_bytes;
      logic [31:0] host_recv_bytes;
      logic [31:0] host_sent_packets;
      logic [31:0] host_recv_packets;
   } req_item_type;

   typedef struct packed {
      logic        is_total;
      logic [3:0]  type_index;
      logic [31:0] send_byte_rate;
      logic [31:0] recv_byte_rate;
      logic [31:0] send_packet_rate;
      logic [31:0] recv_packet_rate;
      logic [63:0] wire_sent_bytes_total;
      logic [63:0] wire_recv_bytes_total;
      logic [63:0] wire_sent_packets_total;
      logic [63:0] wire_recv_packets_total;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic                  rd_en;
      logic [TYPE_IDX_W-1:0] rd_addr;
      logic                  cnt_we;
      logic                  snap_we;
      logic                  rate_we;
      logic [TYPE_IDX_W-1:0] wr_addr;
   } store_ctrl_type;

endpackage

FILE: hdl/trm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_div
// Shared rate divider: min(floor(delta * 1000 / elapsed), 2^32-1), zero for
// an elapsed time of zero. Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module trm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] delta,
   input  logic [31:0] elapsed,
   output logic        done,
   output logic [31:0] quotient
);

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_PREP = 3'b010,
      D_LOOP = 3'b100
   } div_state_type;

   div_state_type state_ff, state_in;
   logic [73:0]   num_ff, num_in;
   logic [31:0]   den_ff, den_in;
   logic [31:0]   rem_ff, rem_in;
   logic [31:0]   lo_ff, lo_in;
   logic [31:0]   quo_ff, quo_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          done_ff, done_in;

   logic [73:0] delta_x;
   logic [32:0] rem_sh;
   logic [32:0] rem_sub;
   logic        ge;

   assign delta_x = {10'd0, delta};
   assign rem_sh  = {rem_ff, lo_ff[31]};
   assign ge      = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         D_IDLE: begin
            if (start) begin
               num_in   = (delta_x << 10) - (delta_x << 4) - (delta_x << 3);
               den_in   = elapsed;
               state_in = D_PREP;
            end
         end
         D_PREP: begin
            if (den_ff == 32'd0) begin
               quo_in   = '0;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else if (num_ff[73:32] >= {10'd0, den_ff}) begin
               quo_in   = '1;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               rem_in   = num_ff[63:32];
               lo_in    = num_ff[31:0];
               cnt_in   = 5'd31;
               state_in = D_LOOP;
            end
         end
         D_LOOP: begin
            rem_in = ge ? rem_sub[31:0] : rem_sh[31:0];
            lo_in  = {lo_ff[30:0], 1'b0};
            quo_in = {quo_ff[30:0], ge};
            if (cnt_ff == 5'd0) begin
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hdl/trm_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_store
// Per-type memories: byte and packet counters, their snapshots and the last rates,
// one word per type, one shared read address, registered read data.
// ----------------------------------------------------------------------------
module trm_store (
   input  logic                    clock,
   input  trm_pkg::store_ctrl_type ctrl,
   input  trm_pkg::quad64_type     cnt_wdata,
   input  trm_pkg::quad64_type     snap_wdata,
   input  trm_pkg::quad32_type     rate_wdata,
   output trm_pkg::quad64_type     cnt_rdata,
   output trm_pkg::quad64_type     snap_rdata,
   output trm_pkg::quad32_type     rate_rdata
);

   trm_pkg::quad64_type cnt_mem  [trm_pkg::NUM_TYPES];
   trm_pkg::quad64_type snap_mem [trm_pkg::NUM_TYPES];
   trm_pkg::quad32_type rate_mem [trm_pkg::NUM_TYPES];

   trm_pkg::quad64_type cnt_rd_ff;
   trm_pkg::quad64_type snap_rd_ff;
   trm_pkg::quad32_type rate_rd_ff;

   always_ff @(posedge clock) begin
      if (ctrl.cnt_we) begin
         cnt_mem[ctrl.wr_addr] <= cnt_wdata;
      end
      if (ctrl.snap_we) begin
         snap_mem[ctrl.wr_addr] <= snap_wdata;
      end
      if (ctrl.rate_we) begin
         rate_mem[ctrl.wr_addr] <= rate_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         cnt_rd_ff  <= cnt_mem[ctrl.rd_addr];
         snap_rd_ff <= snap_mem[ctrl.rd_addr];
         rate_rd_ff <= rate_mem[ctrl.rd_addr];
      end
   end

   assign cnt_rdata  = cnt_rd_ff;
   assign snap_rdata = snap_rd_ff;
   assign rate_rdata = rate_rd_ff;

endmodule

FILE: hdl/per_type_traffic_rate_meter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_type_traffic_rate_meter_unit
// Per-type traffic counters with windowed per-second rates.
//
//   channel  ports                               handshake
//   input    start, busy, req_item               start && !busy
//   result   rsp_valid, rsp_item                 one-cycle strobe
//   config   csr_we, csr_index, csr_wdata        csr_we
//
// A packet item reads its type's counters, then writes them back; a dropped
// one leaves busy low. A sample or clear item without a recompute gives the
// aggregate result, then one result per type. Recompute: 4 * (NUM_TYPES + 1)
// divisions on the shared bit-serial divider. After reset a clearing pass
// zeroes the per-type memories; busy is high meanwhile. Results cannot be
// held off: each is valid for a single cycle on rsp_item.
// ----------------------------------------------------------------------------
module per_type_traffic_rate_meter_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  trm_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   output trm_pkg::rsp_item_type rsp_item,
   input  logic                  csr_we,
   input  logic [trm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]           csr_wdata
);

   localparam int TW = trm_pkg::TYPE_IDX_W;
   localparam logic [TW-1:0] LAST_T   = TW'(trm_pkg::NUM_TYPES - 1);
   localparam logic [8:0]    NTYPES_9 = 9'(trm_pkg::NUM_TYPES);

   typedef enum logic [10:0] {
      S_CLR     = 11'b00000000001,
      S_IDLE    = 11'b00000000010,
      S_PKT_WR  = 11'b00000000100,
      S_DECIDE  = 11'b00000001000,
      S_DLOAD   = 11'b00000010000,
      S_DSTART  = 11'b00000100000,
      S_DWAIT   = 11'b00001000000,
      S_AGG_OUT = 11'b00010000000,
      S_T_RD    = 11'b00100000000,
      S_T_OUT   = 11'b01000000000,
      S_SPARE   = 11'b10000000000
   } state_type;

   typedef enum logic [3:0] {
      M_HOLD  = 4'b0001,
      M_FIRST = 4'b0010,
      M_CALC  = 4'b0100,
      M_CLEAR = 4'b1000
   } mode_type;

   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   trm_pkg::req_item_type req_ff, req_in;
   logic [15:0]           win_ff, win_in;
   logic [15:0]           min_ff, min_in;
   logic                  agg_ff, agg_in;
   logic [1:0]            k_ff, k_in;
   logic [TW-1:0]         t_ff, t_in;
   logic [31:0]           elapsed_ff, elapsed_in;
   logic [31:0]           wstart_ff, wstart_in;
   logic                  rate_started_ff, rate_started_in;
   logic                  wire_started_ff, wire_started_in;
   trm_pkg::quad32_type   agg_rates_ff, agg_rates_in;
   trm_pkg::quad32_type   rsnap_ff, rsnap_in;
   trm_pkg::quad32_type   wsnap_ff, wsnap_in;
   trm_pkg::quad64_type   wtot_ff, wtot_in;
   trm_pkg::quad32_type   res_ff, res_in;
   logic [63:0]           delta_ff, delta_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   trm_pkg::rsp_item_type rsp_ff, rsp_in;

   trm_pkg::store_ctrl_type ctrl;
   trm_pkg::quad64_type     cnt_wd, snap_wd, cnt_rd, snap_rd;
   trm_pkg::quad32_type     rate_wd, rate_rd, host_q, in_host, out_rates;
   logic                    div_start, div_done;
   logic [31:0]             div_q;
   logic [7:0]              t_byte;
   logic [1:0]              byte_k, pkt_k;

   trm_store u_store (
      .clock      (clock),
      .ctrl       (ctrl),
      .cnt_wdata  (cnt_wd),
      .snap_wdata (snap_wd),
      .rate_wdata (rate_wd),
      .cnt_rdata  (cnt_rd),
      .snap_rdata (snap_rd),
      .rate_rdata (rate_rd)
   );

   trm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .delta    (delta_ff),
      .elapsed  (elapsed_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign host_q  = {req_ff.host_recv_packets, req_ff.host_sent_packets,
                     req_ff.host_recv_bytes, req_ff.host_sent_bytes};
   assign in_host = {req_item.host_recv_packets, req_item.host_sent_packets,
                     req_item.host_recv_bytes, req_item.host_sent_bytes};
   assign t_byte  = 8'(t_ff);
   assign byte_k  = {1'b0, req_ff.func[0]};
   assign pkt_k   = {1'b1, req_ff.func[0]};

   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      req_in          = req_ff;
      win_in          = win_ff;
      min_in          = min_ff;
      agg_in          = agg_ff;
      k_in            = k_ff;
      t_in            = t_ff;
      elapsed_in      = elapsed_ff;
      wstart_in       = wstart_ff;
      rate_started_in = rate_started_ff;
      wire_started_in = wire_started_ff;
      agg_rates_in    = agg_rates_ff;
      rsnap_in        = rsnap_ff;
      wsnap_in        = wsnap_ff;
      wtot_in         = wtot_ff;
      res_in          = res_ff;
      delta_in        = delta_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = rsp_ff;
      ctrl            = '0;
      cnt_wd          = cnt_rd;
      snap_wd         = cnt_rd;
      rate_wd         = res_ff;
      out_rates       = '0;
      div_start       = 1'b0;

      if (csr_we) begin
         if (csr_index == trm_pkg::CSR_RATE_WINDOW) begin
            win_in = csr_wdata;
         end else begin
            min_in = csr_wdata;
         end
      end

      case (state_ff)
         S_CLR: begin
            ctrl.cnt_we  = 1'b1;
            ctrl.snap_we = 1'b1;
            ctrl.rate_we = 1'b1;
            ctrl.wr_addr = t_ff;
            cnt_wd       = '0;
            snap_wd      = '0;
            rate_wd      = '0;
            if (t_ff == LAST_T) begin
               t_in     = '0;
               state_in = S_IDLE;
            end else begin
               t_in = t_ff + TW'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in = req_item;
               if (req_item.func == trm_pkg::FUNC_SENT ||
                   req_item.func == trm_pkg::FUNC_RECV) begin
                  if (req_item.packet_size >= min_ff &&
                      {1'b0, req_item.packet_type} < NTYPES_9) begin
                     ctrl.rd_en   = 1'b1;
                     ctrl.rd_addr = req_item.packet_type[TW-1:0];
                     state_in     = S_PKT_WR;
                  end
               end else begin
                  elapsed_in = req_item.current_time_ms - wstart_ff;
                  if (req_item.func == trm_pkg::FUNC_SAMPLE) begin
                     if (!wire_started_ff) begin
                        wire_started_in = 1'b1;
                     end else begin
                        for (int k = 0; k < 4; k++) begin
                           wtot_in[k] = wtot_ff[k] +
                                        64'(32'(in_host[k] - wsnap_ff[k]));
                        end
                     end
                     wsnap_in = in_host;
                  end else begin
                     wire_started_in = 1'b0;
                     wsnap_in        = '0;
                  end
                  state_in = S_DECIDE;
               end
            end
         end
         S_PKT_WR: begin
            cnt_wd[byte_k] = cnt_rd[byte_k] + 64'(req_ff.packet_size);
            cnt_wd[pkt_k]  = cnt_rd[pkt_k] + 64'd1;
            ctrl.cnt_we    = 1'b1;
            ctrl.wr_addr   = req_ff.packet_type[TW-1:0];
            state_in       = S_IDLE;
         end
         S_DECIDE: begin
            if (req_ff.func == trm_pkg::FUNC_ABSENT) begin
               mode_in = M_CLEAR;
            end else if (!rate_started_ff) begin
               mode_in = M_FIRST;
            end else if (elapsed_ff < 32'(win_ff)) begin
               mode_in = M_HOLD;
            end else begin
               mode_in = M_CALC;
            end
            if (req_ff.func != trm_pkg::FUNC_ABSENT && rate_started_ff &&
                elapsed_ff >= 32'(win_ff)) begin
               agg_in   = 1'b1;
               k_in     = 2'd0;
               state_in = S_DLOAD;
            end else begin
               state_in = S_AGG_OUT;
            end
         end
         S_DLOAD: begin
            if (agg_ff) begin
               delta_in = 64'(32'(host_q[k_ff] - rsnap_ff[k_ff]));
            end else if (cnt_rd[k_ff] >= snap_rd[k_ff]) begin
               delta_in = cnt_rd[k_ff] - snap_rd[k_ff];
            end else begin
               delta_in = cnt_rd[k_ff];
            end
            state_in = S_DSTART;
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_done) begin
               res_in[k_ff] = div_q;
               if (k_ff == 2'd3) begin
                  state_in = agg_ff ? S_AGG_OUT : S_T_OUT;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = S_DLOAD;
               end
            end
         end
         S_AGG_OUT: begin
            case (mode_ff)
               M_CALC: begin
                  agg_rates_in = res_ff;
                  rsnap_in     = host_q;
                  wstart_in    = req_ff.current_time_ms;
               end
               M_FIRST: begin
                  agg_rates_in    = '0;
                  rsnap_in        = host_q;
                  wstart_in       = req_ff.current_time_ms;
                  rate_started_in = 1'b1;
               end
               M_CLEAR: begin
                  agg_rates_in    = '0;
                  rsnap_in        = '0;
                  wstart_in       = '0;
                  rate_started_in = 1'b0;
               end
               default: agg_rates_in = agg_rates_ff;
            endcase
            rsp_valid_in                   = 1'b1;
            rsp_in.is_total                = 1'b1;
            rsp_in.type_index              = '0;
            rsp_in.send_byte_rate          = agg_rates_in[0];
            rsp_in.recv_byte_rate          = agg_rates_in[1];
            rsp_in.send_packet_rate        = agg_rates_in[2];
            rsp_in.recv_packet_rate        = agg_rates_in[3];
            rsp_in.wire_sent_bytes_total   = wtot_ff[0];
            rsp_in.wire_recv_bytes_total   = wtot_ff[1];
            rsp_in.wire_sent_packets_total = wtot_ff[2];
            rsp_in.wire_recv_packets_total = wtot_ff[3];
            rsp_in.last                    = 1'b0;
            t_in                           = '0;
            state_in                       = S_T_RD;
         end
         S_T_RD: begin
            ctrl.rd_en   = 1'b1;
            ctrl.rd_addr = t_ff;
            if (mode_ff == M_CALC) begin
               agg_in   = 1'b0;
               k_in     = 2'd0;
               state_in = S_DLOAD;
            end else begin
               state_in = S_T_OUT;
            end
         end
         S_T_OUT: begin
            ctrl.wr_addr = t_ff;
            case (mode_ff)
               M_CALC: begin
                  ctrl.snap_we = 1'b1;
                  ctrl.rate_we = 1'b1;
                  out_rates    = res_ff;
               end
               M_FIRST: begin
                  ctrl.snap_we = 1'b1;
                  ctrl.rate_we = 1'b1;
                  rate_wd      = '0;
               end
               M_CLEAR: begin
                  ctrl.snap_we = 1'b1;
                  ctrl.rate_we = 1'b1;
                  snap_wd      = '0;
                  rate_wd      = '0;
               end
               default: out_rates = rate_rd;
            endcase
            rsp_valid_in            = 1'b1;
            rsp_in                  = '0;
            rsp_in.type_index       = t_byte[3:0];
            rsp_in.send_byte_rate   = out_rates[0];
            rsp_in.recv_byte_rate   = out_rates[1];
            rsp_in.send_packet_rate = out_rates[2];
            rsp_in.recv_packet_rate = out_rates[3];
            rsp_in.last             = (t_ff == LAST_T);
            if (t_ff == LAST_T) begin
               t_in     = '0;
               state_in = S_IDLE;
            end else begin
               t_in     = t_ff + TW'(1);
               state_in = S_T_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLR;
         mode_ff         <= M_HOLD;
         win_ff          <= trm_pkg::RATE_WINDOW_RESET;
         min_ff          <= trm_pkg::MIN_SIZE_RESET;
         agg_ff          <= 1'b0;
         k_ff            <= '0;
         t_ff            <= '0;
         wstart_ff       <= '0;
         rate_started_ff <= 1'b0;
         wire_started_ff <= 1'b0;
         agg_rates_ff    <= '0;
         rsnap_ff        <= '0;
         wsnap_ff        <= '0;
         wtot_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         mode_ff         <= mode_in;
         win_ff          <= win_in;
         min_ff          <= min_in;
         agg_ff          <= agg_in;
         k_ff            <= k_in;
         t_ff            <= t_in;
         wstart_ff       <= wstart_in;
         rate_started_ff <= rate_started_in;
         wire_started_ff <= wire_started_in;
         agg_rates_ff    <= agg_rates_in;
         rsnap_ff        <= rsnap_in;
         wsnap_ff        <= wsnap_in;
         wtot_ff         <= wtot_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      req_ff     <= req_in;
      elapsed_ff <= elapsed_in;
      res_ff     <= res_in;
      delta_ff   <= delta_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_total_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.is_total) |-> !rsp_item.last)
      else $error("aggregate item marked last");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last) |-> !busy)
      else $error("busy after final item of a report");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DWAIT))
      else $error("divider finished outside wait state");

   a_type_no_wire: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.is_total) |->
         (rsp_item.wire_sent_bytes_total == 64'd0 &&
          rsp_item.wire_recv_packets_total == 64'd0))
      else $error("per-type item carries wire totals");

endmodule

FILE: tb/trm_rate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trm_rate_checker
// Watches the item, result and register ports of the per-type traffic rate
// meter. Keeps its own copy of the counters, snapshots, rates and registers,
// predicts the report of every sample and clear item, and compares each
// reported item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module trm_rate_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  trm_pkg::req_item_type         req_item,
   input  logic                          rsp_valid,
   input  trm_pkg::rsp_item_type         rsp_item,
   input  logic                          csr_we,
   input  logic [trm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_wdata,
   output int                            errors,
   output int                            pending
);

   localparam int NT = trm_pkg::NUM_TYPES;

   logic [15:0] window_ms;
   logic [15:0] min_size;

   logic [63:0] byte_cnt [2*NT];
   logic [63:0] pkt_cnt  [2*NT];
   logic [63:0] byte_snap[2*NT];
   logic [63:0] pkt_snap [2*NT];
   logic [31:0] type_rate[NT][4];
   logic [31:0] agg_rate [4];
   logic [31:0] agg_snap [4];
   logic [31:0] wire_snap[4];
   logic [63:0] wire_tot [4];
   logic [31:0] win_start;
   logic        rate_on;
   logic        wire_on;

   trm_pkg::rsp_item_type report_q[$];

   function automatic logic [31:0] per_second(logic [63:0] delta, logic [31:0] elapsed);
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] v;
      if (elapsed == 0) return '0;
      q = delta / elapsed;
      r = delta % elapsed;
      if (q >= 64'h1_0000_0000) return '1;
      v = q * 1000 + (r * 1000) / elapsed;
      if (v >= 64'hFFFF_FFFF) return '1;
      return v[31:0];
   endfunction

   function automatic logic [63:0] grown(logic [63:0] now_v, logic [63:0] snap_v);
      return (now_v >= snap_v) ? now_v - snap_v : now_v;
   endfunction

   task automatic zero_window_state();
      win_start = '0;
      rate_on   = 1'b0;
      for (int k = 0; k < 4; k++) begin
         agg_snap[k] = '0;
         agg_rate[k] = '0;
      end
      for (int t = 0; t < NT; t++)
         for (int k = 0; k < 4; k++) type_rate[t][k] = '0;
      for (int i = 0; i < 2*NT; i++) begin
         byte_snap[i] = '0;
         pkt_snap[i]  = '0;
      end
   endtask

   task automatic take_sample(trm_pkg::req_item_type it);
      logic [31:0] host[4];
      logic [31:0] elapsed;
      logic [31:0] diff;
      host[0] = it.host_sent_bytes;
      host[1] = it.host_recv_bytes;
      host[2] = it.host_sent_packets;
      host[3] = it.host_recv_packets;
      if (!wire_on) wire_on = 1'b1;
      else
         for (int k = 0; k < 4; k++) begin
            diff        = host[k] - wire_snap[k];
            wire_tot[k] += 64'(diff);
         end
      for (int k = 0; k < 4; k++) wire_snap[k] = host[k];
      if (!rate_on) begin
         win_start = it.current_time_ms;
         for (int k = 0; k < 4; k++) begin
            agg_snap[k] = host[k];
            agg_rate[k] = '0;
         end
         for (int i = 0; i < 2*NT; i++) begin
            byte_snap[i] = byte_cnt[i];
            pkt_snap[i]  = pkt_cnt[i];
         end
         for (int t = 0; t < NT; t++)
            for (int k = 0; k < 4; k++) type_rate[t][k] = '0;
         rate_on = 1'b1;
         return;
      end
      elapsed = it.current_time_ms - win_start;
      if (elapsed < 32'(window_ms)) return;
      for (int k = 0; k < 4; k++) begin
         diff        = host[k] - agg_snap[k];
         agg_rate[k] = per_second(64'(diff), elapsed);
         agg_snap[k] = host[k];
      end
      for (int t = 0; t < NT; t++) begin
         type_rate[t][0] = per_second(grown(byte_cnt[t], byte_snap[t]), elapsed);
         type_rate[t][1] = per_second(grown(byte_cnt[NT+t], byte_snap[NT+t]), elapsed);
         type_rate[t][2] = per_second(grown(pkt_cnt[t], pkt_snap[t]), elapsed);
         type_rate[t][3] = per_second(grown(pkt_cnt[NT+t], pkt_snap[NT+t]), elapsed);
         byte_snap[t]    = byte_cnt[t];
         byte_snap[NT+t] = byte_cnt[NT+t];
         pkt_snap[t]     = pkt_cnt[t];
         pkt_snap[NT+t]  = pkt_cnt[NT+t];
      end
      win_start = it.current_time_ms;
   endtask

   task automatic push_report();
      trm_pkg::rsp_item_type r;
      r = '0;
      r.is_total                = 1'b1;
      r.send_byte_rate          = agg_rate[0];
      r.recv_byte_rate          = agg_rate[1];
      r.send_packet_rate        = agg_rate[2];
      r.recv_packet_rate        = agg_rate[3];
      r.wire_sent_bytes_total   = wire_tot[0];
      r.wire_recv_bytes_total   = wire_tot[1];
      r.wire_sent_packets_total = wire_tot[2];
      r.wire_recv_packets_total = wire_tot[3];
      report_q.push_back(r);
      for (int t = 0; t < NT; t++) begin
         r = '0;
         r.type_index       = 4'(t);
         r.send_byte_rate   = type_rate[t][0];
         r.recv_byte_rate   = type_rate[t][1];
         r.send_packet_rate = type_rate[t][2];
         r.recv_packet_rate = type_rate[t][3];
         r.last             = (t == NT - 1);
         report_q.push_back(r);
      end
   endtask

   task automatic apply_item(trm_pkg::req_item_type it);
      int idx;
      case (it.func)
         trm_pkg::FUNC_SENT, trm_pkg::FUNC_RECV: begin
            if (it.packet_size >= min_size && it.packet_type < NT) begin
               idx = (it.func == trm_pkg::FUNC_RECV ? NT : 0) + int'(it.packet_type);
               byte_cnt[idx] += 64'(it.packet_size);
               pkt_cnt[idx]  += 64'd1;
            end
         end
         trm_pkg::FUNC_SAMPLE: begin
            take_sample(it);
            push_report();
         end
         trm_pkg::FUNC_ABSENT: begin
            zero_window_state();
            wire_on = 1'b0;
            for (int k = 0; k < 4; k++) wire_snap[k] = '0;
            push_report();
         end
         default: ;
      endcase
   endtask

   task automatic check_result(trm_pkg::rsp_item_type got);
      trm_pkg::rsp_item_type want;
      logic                  bad;
      if (report_q.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result item: %p", got);
         return;
      end
      want = report_q.pop_front();
      bad = (got.is_total !== want.is_total) || (got.type_index !== want.type_index) ||
            (got.send_byte_rate !== want.send_byte_rate) ||
            (got.recv_byte_rate !== want.recv_byte_rate) ||
            (got.send_packet_rate !== want.send_packet_rate) ||
            (got.recv_packet_rate !== want.recv_packet_rate) ||
            (got.wire_sent_bytes_total !== want.wire_sent_bytes_total) ||
            (got.wire_recv_bytes_total !== want.wire_recv_bytes_total) ||
            (got.wire_sent_packets_total !== want.wire_sent_packets_total) ||
            (got.wire_recv_packets_total !== want.wire_recv_packets_total) ||
            (got.last !== want.last);
      if (bad) begin
         errors++;
         if (errors <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %p", want);
            $display("  actual   %p", got);
         end
      end
   endtask

   initial begin
      errors  = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         window_ms = trm_pkg::RATE_WINDOW_RESET;
         min_size  = trm_pkg::MIN_SIZE_RESET;
         for (int i = 0; i < 2*NT; i++) begin
            byte_cnt[i] = '0;
            pkt_cnt[i]  = '0;
         end
         zero_window_state();
         for (int k = 0; k < 4; k++) begin
            wire_snap[k] = '0;
            wire_tot[k]  = '0;
         end
         wire_on = 1'b0;
         report_q.delete();
      end else begin
         if (rsp_valid) check_result(rsp_item);
         if (csr_we) begin
            if (csr_index == trm_pkg::CSR_RATE_WINDOW) window_ms = csr_wdata;
            else if (csr_index == trm_pkg::CSR_MIN_SIZE) min_size = csr_wdata;
         end
         if (start && !busy) apply_item(req_item);
      end
      pending = report_q.size();
   end

endmodule

FILE: tb/tb_per_type_traffic_rate_meter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_type_traffic_rate_meter_unit
// Drives packet, sample and clear items into the traffic rate meter through
// several register settings, with random gaps, and leaves prediction and
// comparison to the checker beside it. Gives the verdict at the end.
// ----------------------------------------------------------------------------
module tb_per_type_traffic_rate_meter_unit;

   localparam int WATCHDOG_LIMIT = 20000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   trm_pkg::req_item_type         req_item = '0;
   logic                          rsp_valid;
   trm_pkg::rsp_item_type         rsp_item;
   logic                          csr_we = 1'b0;
   logic [trm_pkg::CSR_IDX_W-1:0] csr_index = trm_pkg::CSR_RATE_WINDOW;
   logic [15:0]                   csr_wdata = '0;
   int                            errors;
   int                            pending;
   int                            idle_cycles = 0;

   logic [31:0] now_ms;
   logic [31:0] host[4];
   int          window_ms;
   bit          gaps_on;

   per_type_traffic_rate_meter_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   trm_rate_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_item(logic [1:0] f, logic [7:0] ptype, logic [15:0] psize,
                            logic [31:0] tm);
      req_item <= '{f, ptype, psize, tm, host[0], host[1], host[2], host[3]};
      start    <= 1'b1;
      do @(negedge clock); while (busy);
      @(posedge clock);
      if (gaps_on && $urandom_range(3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // drain, settle, then write both registers
   task automatic set_registers(int win, int msz);
      start <= 1'b0;
      do @(negedge clock); while (pending != 0 || busy);
      repeat (100) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= trm_pkg::CSR_RATE_WINDOW;
      csr_wdata <= 16'(win);
      @(posedge clock);
      csr_index <= trm_pkg::CSR_MIN_SIZE;
      csr_wdata <= 16'(msz);
      @(posedge clock);
      csr_we <= 1'b0;
      window_ms = win;
   endtask

   initial begin
      int win_list[6];
      int msz_list[6];
      int pick;
      win_list = '{1000, 1, 65535, 0, 50, 0};
      msz_list = '{4, 0, 65535, 0, 64, 0};
      win_list[5] = $urandom_range(1, 65535);
      msz_list[5] = $urandom_range(0, 65535);
      window_ms = 1000;
      gaps_on   = 1'b0;
      now_ms    = '0;
      for (int k = 0; k < 4; k++) host[k] = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send_item(trm_pkg::FUNC_SAMPLE, 8'd0, 16'd0, 32'd0);
      send_item(trm_pkg::FUNC_SENT, 8'd0, 16'hFFFF, '0);
      send_item(trm_pkg::FUNC_RECV, 8'd15, 16'd4, '0);
      send_item(trm_pkg::FUNC_SENT, 8'd3, 16'd3, '0);
      send_item(trm_pkg::FUNC_RECV, 8'd16, 16'd100, '0);
      send_item(trm_pkg::FUNC_SENT, 8'hFF, 16'hFFFF, '0);
      host[0] = 32'd500;
      send_item(trm_pkg::FUNC_SAMPLE, 8'd0, 16'd0, 32'd999);
      for (int k = 0; k < 4; k++) host[k] = 32'hFFFF_FFFF;
      send_item(trm_pkg::FUNC_SAMPLE, 8'd0, 16'd0, 32'd1000);
      send_item(trm_pkg::FUNC_SENT, 8'd7, 16'd1500, '0);
      for (int k = 0; k < 4; k++) host[k] = 32'h0000_0010;
      send_item(trm_pkg::FUNC_SAMPLE, 8'd0, 16'd0, 32'hFFFF_FFFF);
      send_item(trm_pkg::FUNC_ABSENT, 8'd0, 16'd0, '0);
      send_item(trm_pkg::FUNC_SAMPLE, 8'd0, 16'd0, 32'd5);
      send_item(trm_pkg::FUNC_RECV, 8'd2, 16'd9000, '0);
      for (int k = 0; k < 4; k++) host[k] = host[k] + 32'd123456;
      send_item(trm_pkg::FUNC_SAMPLE, 8'd0, 16'd0, 32'd2005);
      now_ms = 32'd2005;

      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) set_registers(win_list[ph], msz_list[ph]);
         for (int n = 0; n < 70; n++) begin
            if (n % 20 == 0) gaps_on = (ph < 5) && $urandom_range(2) != 0;
            pick = $urandom_range(99);
            if (pick < 84) begin
               if ($urandom_range(9) == 0)
                  send_item(pick < 42 ? trm_pkg::FUNC_SENT : trm_pkg::FUNC_RECV,
                            8'($urandom_range(255)), 16'($urandom), 32'($urandom));
               else
                  send_item(pick < 42 ? trm_pkg::FUNC_SENT : trm_pkg::FUNC_RECV,
                            8'($urandom_range(trm_pkg::NUM_TYPES - 1)),
                            ($urandom_range(3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 1600)),
                            '0);
            end else if (pick < 97) begin
               for (int k = 0; k < 4; k++)
                  if ($urandom_range(7) == 0) host[k] = $urandom;
                  else host[k] = host[k] + 32'($urandom_range(0, 200000));
               case ($urandom_range(9))
                  0: now_ms = now_ms + 32'($urandom_range(0, window_ms > 0 ? window_ms - 1 : 0));
                  1: now_ms = $urandom;
                  default: now_ms = now_ms + 32'(window_ms) + 32'($urandom_range(0, 3000));
               endcase
               send_item(trm_pkg::FUNC_SAMPLE, 8'($urandom), 16'($urandom), now_ms);
            end else begin
               send_item(trm_pkg::FUNC_ABSENT, 8'($urandom), 16'($urandom), 32'($urandom));
            end
         end
      end
      start <= 1'b0;

      do @(negedge clock); while (pending != 0);
      repeat (200) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/trm_pkg.sv
hdl/trm_div.sv
hdl/trm_store.sv
hdl/per_type_traffic_rate_meter_unit.sv
tb/trm_rate_checker.sv
tb/tb_per_type_traffic_rate_meter_unit.sv
